// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;

    localparam int unsigned PAGE_W = 8;
    localparam int unsigned PAGES = 256;
    localparam int unsigned WEIGHT_W = 24;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned LIMIT_W = 5;
    localparam int unsigned NUM_WEIGHTS = 7;
    localparam int unsigned WIN_SHORT = 10;
    localparam int unsigned WIN_MEDIUM = 50;
    localparam int unsigned SCORE_W = 64;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_LIMIT = 3'd0;
    localparam logic [2:0] REG_W_SHORT = 3'd1;
    localparam logic [2:0] REG_W_MEDIUM = 3'd2;
    localparam logic [2:0] REG_W_LONG = 3'd3;
    localparam logic [2:0] REG_W_RECENCY = 3'd4;
    localparam logic [2:0] REG_W_LAST_GAP = 3'd5;
    localparam logic [2:0] REG_W_MEAN_GAP = 3'd6;
    localparam logic [2:0] REG_W_REUSES = 3'd7;

    typedef logic signed [WEIGHT_W-1:0] t_weight;

    // One history entry broadcast along the chain of cells.
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic [PAGE_W-1:0]     page;
    } t_hist_beat;

endpackage

// ===== rtl/lpr_stream_if.sv =====
interface lpr_stream_if #(
    parameter int unsigned WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/learned_page_replacement_unit.sv =====
// Learned page replacement unit.
// Requests arrive on i_req (one page number each) and each request yields
// exactly one result on o_rsp: hit flag, frame slot, and the evicted page.
// Configuration is written via i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// write it only while idle, which the block does not enforce. Register 0 is
// the frame limit, 1..7 the signed Q7.16 weights.
// The frame search walks one frame per cycle. A hit or a fill goes from the
// search through a finish state, which writes the page into the history, to
// the output state; once the result leaves, the block returns to idle and
// then takes the next request. A miss with all frames in use first broadcasts
// the history ring through the chain of frame cells, one entry per cycle, then
// scores the frames below the effective frame limit in turn with one shared
// divider and multiplier; the divider is skipped when a frame's page has no reuse.
// One request is worked on at a time; the result is held in an output
// register until the receiver takes it, and a stalled receiver keeps the
// block from taking the next request.
// Reset (synchronous, active low) empties the frame table and history and
// sets the frame limit to 16 and all weights to zero.
module learned_page_replacement_unit #(
    parameter int unsigned FRAMES = 16,
    parameter int unsigned HISTORY = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpr_stream_if.sink   i_req,
    lpr_stream_if.source o_rsp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [lpr_pkg::WEIGHT_W-1:0] i_cfg_data
);
    localparam int unsigned HIST_W = $clog2(HISTORY + 1);
    localparam int unsigned HIDX_W = $clog2(HISTORY);
    localparam int unsigned FR_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned FCNT_W = $clog2(FRAMES + 1);
    localparam int unsigned PW = lpr_pkg::PAGE_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_SCORE = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;

    logic [2:0] r_state;
    logic [lpr_pkg::LIMIT_W-1:0] r_limit;
    lpr_pkg::t_weight r_weights [lpr_pkg::NUM_WEIGHTS];
    logic [PW-1:0] r_hist [HISTORY];
    logic [HIST_W-1:0] r_fill;
    logic [HIDX_W-1:0] r_head;
    logic [FCNT_W-1:0] r_resident;
    logic [PW-1:0] r_page;
    logic [FCNT_W-1:0] r_idx;
    logic [HIST_W-1:0] r_k;
    logic [HIDX_W-1:0] r_rd;
    lpr_pkg::t_hist_beat r_beat;
    logic [HIST_W-1:0] r_beat_k;
    logic [PW-1:0] r_hist_q;
    logic signed [lpr_pkg::SCORE_W-1:0] r_best;
    logic [FR_W-1:0] r_slot;
    logic r_hit, r_ev_valid;
    logic [PW-1:0] r_ev_page;
    logic r_start;

    logic [FCNT_W-1:0] limit_eff;
    logic [PW-1:0] in_page;
    logic [FR_W-1:0] idx_fr;
    logic load [FRAMES];
    logic [PW-1:0] c_page [FRAMES];
    logic [HIST_W-1:0] c_short [FRAMES];
    logic [HIST_W-1:0] c_med [FRAMES];
    logic [HIST_W-1:0] c_long [FRAMES];
    logic [HIST_W-1:0] c_reuses [FRAMES];
    logic [HIST_W-1:0] c_last_k [FRAMES];
    logic c_seen [FRAMES];
    logic [HIST_W-1:0] c_last_gap [FRAMES];
    logic [2*HIST_W-1:0] c_gap_sum [FRAMES];
    logic [HIST_W-1:0] beat_age;
    logic [HIST_W-1:0] sel_recency, sel_last_gap;
    logic sc_done;
    logic signed [lpr_pkg::SCORE_W-1:0] sc_score;
    logic [HIST_W:0] oldest_sum;
    logic [HIDX_W-1:0] oldest;

    assign in_page = PW'(i_req.data % lpr_pkg::PAGES);
    assign idx_fr = r_idx[FR_W-1:0];
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = (r_state == ST_OUT);
    assign o_rsp.data = {r_hit, 4'(r_slot), r_ev_valid, r_ev_page};

    // Effective frame limit: zero means one, above FRAMES means FRAMES.
    always_comb begin
        if (r_limit == '0) begin
            limit_eff = FCNT_W'(1);
        end else if (32'(r_limit) > FRAMES) begin
            limit_eff = FCNT_W'(FRAMES);
        end else begin
            limit_eff = FCNT_W'(r_limit);
        end
    end

    // Oldest history slot for the scan.
    assign oldest_sum = (HIST_W+1)'(r_head) + (HIST_W+1)'(HISTORY) - (HIST_W+1)'(r_fill);
    assign oldest = (oldest_sum >= (HIST_W+1)'(HISTORY))
                  ? HIDX_W'(oldest_sum - (HIST_W+1)'(HISTORY)) : HIDX_W'(oldest_sum);
    assign beat_age = r_fill - HIST_W'(1) - r_beat_k;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lpr_pkg::LIMIT_W'(16);
            for (int i = 0; i < lpr_pkg::NUM_WEIGHTS; i++) begin
                r_weights[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lpr_pkg::REG_FRAME_LIMIT) begin
                r_limit <= i_cfg_data[lpr_pkg::LIMIT_W-1:0];
            end else begin
                r_weights[i_cfg_idx - 3'd1] <= i_cfg_data;
            end
        end
    end

    // History memory: one write at request end, one registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            r_hist[r_head] <= r_page;
        end
        r_hist_q <= r_hist[r_rd];
    end

    // Chain of frame cells.
    for (genvar f = 0; f < FRAMES; f++) begin : g_cell
        assign load[f] = (r_state == ST_FINISH) && !r_hit && (idx_fr == FR_W'(f))
                       ? 1'b1 : 1'b0;
        lpr_cell #(.HIST_W(HIST_W)) u_cell (
            .i_clk      (i_clk),
            .i_beat     (r_beat),
            .i_age      (beat_age),
            .i_k        (r_beat_k),
            .i_load     (load[f]),
            .i_load_page(r_page),
            .o_page     (c_page[f]),
            .o_c_short  (c_short[f]),
            .o_c_med    (c_med[f]),
            .o_c_long   (c_long[f]),
            .o_reuses   (c_reuses[f]),
            .o_last_k   (c_last_k[f]),
            .o_seen     (c_seen[f]),
            .o_last_gap (c_last_gap[f]),
            .o_gap_sum  (c_gap_sum[f])
        );
    end

    assign sel_recency = c_seen[idx_fr] ? (r_fill - HIST_W'(1) - c_last_k[idx_fr])
                                        : HIST_W'(HISTORY);
    assign sel_last_gap = (c_reuses[idx_fr] != '0) ? c_last_gap[idx_fr] : HIST_W'(HISTORY);

    lpr_scorer #(.HIST_W(HIST_W)) u_scorer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_c_short (c_short[idx_fr]),
        .i_c_med   (c_med[idx_fr]),
        .i_c_long  (c_long[idx_fr]),
        .i_recency (sel_recency),
        .i_last_gap(sel_last_gap),
        .i_gap_sum (c_gap_sum[idx_fr]),
        .i_reuses  (c_reuses[idx_fr]),
        .i_weights (r_weights),
        .o_done    (sc_done),
        .o_score   (sc_score)
    );

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0;
            r_head <= '0;
            r_resident <= '0;
            r_beat.valid <= 1'b0;
            r_beat.first <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            r_beat.valid <= 1'b0;
            r_beat.first <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_page <= in_page;
                        r_idx <= '0;
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (r_idx < r_resident && c_page[idx_fr] == r_page) begin
                        r_hit <= 1'b1;
                        r_slot <= idx_fr;
                        r_ev_valid <= 1'b0;
                        r_ev_page <= '0;
                        r_state <= ST_FINISH;
                    end else if (r_idx + FCNT_W'(1) < r_resident) begin
                        r_idx <= r_idx + FCNT_W'(1);
                    end else if (r_resident < limit_eff) begin
                        r_hit <= 1'b0;
                        r_idx <= r_resident;
                        r_slot <= FR_W'(r_resident);
                        r_ev_valid <= 1'b0;
                        r_ev_page <= '0;
                        r_resident <= r_resident + FCNT_W'(1);
                        r_state <= ST_FINISH;
                    end else begin
                        r_hit <= 1'b0;
                        r_k <= '0;
                        r_rd <= oldest;
                        r_beat.first <= 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Memory read is registered: each beat carries the entry of index r_k - 1.
                    if (r_k < r_fill) begin
                        r_rd <= (r_rd == HIDX_W'(HISTORY - 1)) ? '0 : r_rd + HIDX_W'(1);
                        r_k <= r_k + HIST_W'(1);
                    end
                    r_beat.valid <= (r_k != '0) && (r_k <= r_fill);
                    r_beat.page <= r_hist_q;
                    r_beat_k <= r_k - HIST_W'(1);
                    if (r_k > r_fill || (r_k == r_fill && r_fill == '0)) begin
                        r_idx <= '0;
                        r_start <= 1'b1;
                        r_state <= ST_SCORE;
                    end else if (r_k == r_fill) begin
                        r_k <= r_k + HIST_W'(1);
                    end
                end
                ST_SCORE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (sc_done) begin
                        if (r_idx == '0 || sc_score > r_best) begin
                            r_best <= sc_score;
                            r_slot <= idx_fr;
                        end
                        if (r_idx + FCNT_W'(1) < limit_eff) begin
                            r_idx <= r_idx + FCNT_W'(1);
                            r_start <= 1'b1;
                            r_state <= ST_SCORE;
                        end else begin
                            r_state <= ST_FINISH;
                            r_ev_valid <= 1'b1;
                            r_idx <= (r_idx == '0 || sc_score > r_best)
                                   ? r_idx : FCNT_W'(r_slot);
                            r_ev_page <= (r_idx == '0 || sc_score > r_best)
                                       ? c_page[idx_fr] : c_page[r_slot];
                        end
                    end
                end
                ST_FINISH: begin
                    r_head <= (r_head == HIDX_W'(HISTORY - 1)) ? '0 : r_head + HIDX_W'(1);
                    if (r_fill < HIST_W'(HISTORY)) begin
                        r_fill <= r_fill + HIST_W'(1);
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/lpr_cell.sv =====
// One frame cell: holds its page and gathers the feature counters as the
// history goes past, oldest entry first, one entry per cycle.
module lpr_cell #(
    parameter int unsigned HIST_W = 7
) (
    input  logic                       i_clk,
    input  lpr_pkg::t_hist_beat        i_beat,
    input  logic [HIST_W-1:0]          i_age,
    input  logic [HIST_W-1:0]          i_k,
    input  logic                       i_load,
    input  logic [lpr_pkg::PAGE_W-1:0] i_load_page,
    output logic [lpr_pkg::PAGE_W-1:0] o_page,
    output logic [HIST_W-1:0]          o_c_short,
    output logic [HIST_W-1:0]          o_c_med,
    output logic [HIST_W-1:0]          o_c_long,
    output logic [HIST_W-1:0]          o_reuses,
    output logic [HIST_W-1:0]          o_last_k,
    output logic                       o_seen,
    output logic [HIST_W-1:0]          o_last_gap,
    output logic [2*HIST_W-1:0]        o_gap_sum
);
    logic [lpr_pkg::PAGE_W-1:0] r_page;
    logic [HIST_W-1:0] r_c_short, r_c_med, r_c_long, r_reuses, r_last_k, r_last_gap;
    logic [2*HIST_W-1:0] r_gap_sum;
    logic r_seen;
    logic match;
    logic [HIST_W-1:0] gap;

    assign match = i_beat.valid && (i_beat.page == r_page);
    assign gap = i_k - r_last_k - HIST_W'(1);

    // Page store, written on fill or eviction.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_page <= i_load_page;
        end
    end

    // Feature counters; the first beat of a scan clears them.
    always_ff @(posedge i_clk) begin
        if (i_beat.first) begin
            r_c_short <= '0;
            r_c_med <= '0;
            r_c_long <= '0;
            r_reuses <= '0;
            r_seen <= 1'b0;
            r_last_k <= '0;
            r_last_gap <= '0;
            r_gap_sum <= '0;
        end else if (match) begin
            if (i_age < HIST_W'(lpr_pkg::WIN_SHORT)) begin
                r_c_short <= r_c_short + HIST_W'(1);
            end
            if (i_age < HIST_W'(lpr_pkg::WIN_MEDIUM)) begin
                r_c_med <= r_c_med + HIST_W'(1);
            end
            r_c_long <= r_c_long + HIST_W'(1);
            if (r_seen) begin
                r_reuses <= r_reuses + HIST_W'(1);
                r_last_gap <= gap;
                r_gap_sum <= r_gap_sum + (2*HIST_W)'(gap);
            end
            r_seen <= 1'b1;
            r_last_k <= i_k;
        end
    end

    assign o_page = r_page;
    assign o_c_short = r_c_short;
    assign o_c_med = r_c_med;
    assign o_c_long = r_c_long;
    assign o_reuses = r_reuses;
    assign o_last_k = r_last_k;
    assign o_seen = r_seen;
    assign o_last_gap = r_last_gap;
    assign o_gap_sum = r_gap_sum;
endmodule

// ===== rtl/lpr_scorer.sv =====
// Scores one frame: a restoring divider for the mean gap (skipped when there is
// no reuse), then seven weighted terms accumulated one per cycle through a single multiplier.
module lpr_scorer #(
    parameter int unsigned HIST_W = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [HIST_W-1:0]            i_c_short,
    input  logic [HIST_W-1:0]            i_c_med,
    input  logic [HIST_W-1:0]            i_c_long,
    input  logic [HIST_W-1:0]            i_recency,
    input  logic [HIST_W-1:0]            i_last_gap,
    input  logic [2*HIST_W-1:0]          i_gap_sum,
    input  logic [HIST_W-1:0]            i_reuses,
    input  lpr_pkg::t_weight             i_weights [lpr_pkg::NUM_WEIGHTS],
    output logic                         o_done,
    output logic signed [lpr_pkg::SCORE_W-1:0] o_score
);
    localparam int unsigned NUM_W = 2*HIST_W + 16;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_MAC = 2'd2;

    logic [1:0] r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [HIST_W:0] r_rem;
    logic [HIST_W-1:0] r_feat [lpr_pkg::NUM_WEIGHTS];
    logic [2:0] r_term;
    logic signed [lpr_pkg::SCORE_W-1:0] r_acc;
    logic r_done;

    logic [HIST_W+1:0] trial;
    logic [HIST_W:0] shifted;
    logic [NUM_W-1:0] feat_val;
    logic signed [lpr_pkg::WEIGHT_W+NUM_W:0] mul;
    logic signed [lpr_pkg::SCORE_W-1:0] product;

    assign shifted = {r_rem[HIST_W-1:0], r_quot[NUM_W-1]};
    assign trial = {1'b0, shifted} - {2'b0, i_reuses};

    // Term selection: integer features are placed at Q.16.
    always_comb begin
        if (r_term == lpr_pkg::REG_W_MEAN_GAP - 3'd1) begin
            feat_val = r_quot;
        end else begin
            feat_val = NUM_W'({r_feat[r_term], 16'h0});
        end
    end

    // The weight is 24 bits and the feature 30, so the product fits well short of 64 bits.
    assign mul = i_weights[r_term] * $signed({1'b0, feat_val});
    assign product = lpr_pkg::SCORE_W'(mul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= (i_reuses == '0) ? ST_MAC : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (r_term == 3'(lpr_pkg::NUM_WEIGHTS - 1)) begin
                        r_state <= ST_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath: latch features, shift-subtract division, accumulate.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_feat[0] <= i_c_short;
            r_feat[1] <= i_c_med;
            r_feat[2] <= i_c_long;
            r_feat[3] <= i_recency;
            r_feat[4] <= i_last_gap;
            r_feat[5] <= '0;
            r_feat[6] <= i_reuses;
            r_quot <= {i_gap_sum, 16'h0};
            r_rem <= '0;
            r_cnt <= '0;
            r_term <= '0;
            r_acc <= '0;
        end else if (r_state == ST_DIV) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!trial[HIST_W+1]) begin
                r_rem <= trial[HIST_W:0];
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end else if (r_state == ST_MAC) begin
            r_acc <= r_acc + product;
            r_term <= r_term + 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_score = r_acc;
endmodule
